>>> src/wbpm_pkg.sv
// Package for the wildcard byte pattern matcher: item types, configuration
// register codes and defaults. No dependencies.
package wbpm_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int REG_BYTES  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO = 3'd0,
		REG_PAT_HI = 3'd1,
		REG_WILD   = 3'd2,
		REG_LEN    = 3'd3,
		REG_FIRST  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] pat_lo;
		logic [63:0] pat_hi;
		logic [15:0] wild;
		logic [4:0]  len;
		logic        first_only;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        match_found;
		logic [31:0] match_offset;
		logic        region_end;
	} out_item_t;

endpackage

>>> src/wbpm_if.sv
// Valid/ready channel interfaces for the pattern matcher's input and output.
// Depends on wbpm_pkg for the item types.
interface wbpm_in_if;
	import wbpm_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface wbpm_out_if;
	import wbpm_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

>>> src/wbpm_cell.sv
// One window cell: holds one byte of the recent history, passes it on to the
// next cell and compares it with its aligned pattern position. Uses wbpm_pkg.
module wbpm_cell #(
	parameter int PATTERN_MAX = wbpm_pkg::PATTERN_MAX_DEF,
	parameter int IDX = 0
) (
	input  logic                                 clk,
	input  logic                                 shift_en,
	input  logic [7:0]                           byte_in,
	output logic [7:0]                           byte_out,
	input  wbpm_pkg::cfg_t                       cfg,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]     len_used,
	output logic                                 hit
);
	import wbpm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [7:0]       byte_q;
	logic [LEN_W-1:0] pos;
	logic [3:0]       pos_idx;
	logic [127:0]     pat_all;
	logic [7:0]       pat_byte;
	logic             pat_wild;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign pat_all  = {cfg.pat_hi, cfg.pat_lo};

	// The byte held IDX steps back lines up with pattern position len-1-IDX.
	always_comb begin
		pos      = len_used - LEN_W'(IDX + 1);
		pos_idx  = 4'(pos);
		pat_byte = 8'h00;
		pat_wild = 1'b0;
		if (32'(pos) < REG_BYTES) begin
			pat_byte = pat_all[8*pos_idx +: 8];
			pat_wild = cfg.wild[pos_idx];
		end
		if (32'(len_used) <= IDX) begin
			hit = 1'b1;
		end else begin
			hit = pat_wild || (byte_q == pat_byte);
		end
	end

endmodule

>>> src/wildcard_byte_pattern_matcher.sv
// Wildcard byte pattern matcher, top level.
// Throughput: one byte per cycle unless the output stalls; the window is a
// row of shift cells with a comparator each, so one compare stage and one
// output register set the pace.
// Reset clears configuration (length 1), byte count, match flag and valids.
module wildcard_byte_pattern_matcher #(
	parameter int PATTERN_MAX = wbpm_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = wbpm_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	wbpm_in_if.sink                           in_ch,
	wbpm_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [wbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wbpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wbpm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W = OFFSET_BITS + 1;

	cfg_t                   cfg_q;
	logic [LEN_W-1:0]       len_used;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_next;
	logic [CNT_W-1:0]       cnt_s1;
	logic                   last_s1;
	logic                   valid_s1;
	logic                   found_q;
	logic                   out_valid_q;
	out_item_t              out_item_q;
	logic [PATTERN_MAX-1:0] hits;
	logic [7:0]             chain [PATTERN_MAX+1];
	logic                   in_accept;
	logic                   match;
	logic                   report;
	logic                   produce;
	logic                   s1_go;
	logic                   s1_fire;
	logic [CNT_W-1:0]       offset_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q            <= '0;
			cfg_q.len        <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LO: cfg_q.pat_lo     <= cfg_data;
				REG_PAT_HI: cfg_q.pat_hi     <= cfg_data;
				REG_WILD:   cfg_q.wild       <= cfg_data[15:0];
				REG_LEN:    cfg_q.len        <= cfg_data[4:0];
				REG_FIRST:  cfg_q.first_only <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_q.len == 5'd0) begin
			len_used = LEN_W'(1);
		end else if (32'(cfg_q.len) > PATTERN_MAX) begin
			len_used = LEN_W'(PATTERN_MAX);
		end else begin
			len_used = LEN_W'(cfg_q.len);
		end
	end

	// Window cells shift on every input transfer.
	assign chain[0] = in_ch.item.data_byte;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		wbpm_cell #(
			.PATTERN_MAX(PATTERN_MAX),
			.IDX(k)
		) u_cell (
			.clk      (clk),
			.shift_en (in_accept),
			.byte_in  (chain[k]),
			.byte_out (chain[k+1]),
			.cfg      (cfg_q),
			.len_used (len_used),
			.hit      (hits[k])
		);
	end

	assign count_next = (&count_q) ? count_q : count_q + CNT_W'(1);

	// Bytes older than the region may sit in the cells; the count check keeps
	// them out of any match.
	assign match       = (cnt_s1 >= CNT_W'(len_used)) && (&hits);
	assign report      = match && (!cfg_q.first_only || !found_q);
	assign produce     = report || last_s1;
	assign s1_go       = !produce || !out_valid_q || out_ch.ready;
	assign s1_fire     = valid_s1 && s1_go;
	assign in_ch.ready = !valid_s1 || s1_go;
	assign in_accept   = in_ch.valid && in_ch.ready;
	assign offset_full = cnt_s1 - CNT_W'(len_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				count_q  <= in_ch.item.last_byte ? '0 : count_next;
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			if (s1_fire) begin
				if (last_s1) begin
					found_q <= 1'b0;
				end else if (report) begin
					found_q <= 1'b1;
				end
			end

			if (s1_fire && produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cnt_s1  <= count_next;
			last_s1 <= in_ch.item.last_byte;
		end
		if (s1_fire && produce) begin
			out_item_q.match_found  <= report;
			out_item_q.match_offset <= report ? 32'(offset_full[OFFSET_BITS-1:0]) : 32'd0;
			out_item_q.region_end   <= last_s1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_item_q;

endmodule

>>> src/wbpm_checker.sv
// Port-level checks for the wildcard byte pattern matcher, bound to the top
// level. Depends on wbpm_pkg and the top level's output channel interface.
module wbpm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input wbpm_pkg::out_item_t out_item
);
	import wbpm_pkg::*;

	// A stalled result must stay put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Every result carries either a match or the end of a region.
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.match_found || out_item.region_end)
		else $error("result with neither match nor region end");

	// A region end without a match reports offset zero.
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.match_found |-> out_item.match_offset == 32'd0)
		else $error("nonzero offset without a match");

endmodule

bind wildcard_byte_pattern_matcher wbpm_checker u_wbpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.item)
);
